[src/tcg_pkg.sv]
// Shared types, codes and defaults of the text console grid engine.
package tcg_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_TAB_STOP = 8;

   localparam logic [7:0] DEF_NUM_COLS = 8'd80;
   localparam logic [6:0] DEF_NUM_ROWS = 7'd25;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd1;

   localparam logic [2:0] REQ_PUT     = 3'd0;
   localparam logic [2:0] REQ_CLEAR   = 3'd1;
   localparam logic [2:0] REQ_SAVE    = 3'd2;
   localparam logic [2:0] REQ_RESTORE = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_BLANK = 8'd0;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_PLAIN,
      ST_ROWSET,
      ST_ROWCLR,
      ST_CLEAR,
      ST_COPY,
      ST_DRAIN,
      ST_RDCAP,
      ST_RESP
   } tcg_state_type;

endpackage

[src/text_console_grid_engine.sv]
// Top level of the text console grid engine: registers, grid and save RAMs, sequencer.
//
//  channel  | ports                                            | handshake
//  ---------+--------------------------------------------------+---------------------------
//  request  | req_type req_char_code req_cell_col req_cell_row | start & !busy
//  response | rsp_cell_char rsp_cursor_col rsp_cursor_row      | rsp_valid, one cycle
//           | rsp_status                                       |
//  csr      | csr_index csr_wdata                              | csr_valid & csr_ready
//
// A tab writes spaces up to the next tab stop, and a scroll adds a walk that blanks the new
// bottom row. Clear, save and restore walk the grid one cell per cycle over the single
// write port of the grid RAM. After reset, busy stays high while the grid is blanked.
// The receiver cannot stall: each response is presented for exactly one cycle.
module text_console_grid_engine
   import tcg_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_type,
   input  logic [7:0]           req_char_code,
   input  logic [6:0]           req_cell_col,
   input  logic [5:0]           req_cell_row,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_cell_char,
   output logic [7:0]           rsp_cursor_col,
   output logic [5:0]           rsp_cursor_row,
   output logic                 rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]     num_cols_ff, num_cols_in;
   logic [6:0]     num_rows_ff, num_rows_in;
   logic [CW-1:0]  cols;
   logic [RCW-1:0] rows;

   logic           grid_wr_en, sv_wr_en;
   logic [AW-1:0]  grid_wr_addr, grid_rd_addr, sv_wr_addr, sv_rd_addr;
   logic [7:0]     grid_wr_data, grid_rd_data, sv_wr_data, sv_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      num_cols_in = num_cols_ff;
      num_rows_in = num_rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_COLS: num_cols_in = csr_wdata;
            CSR_NUM_ROWS: num_rows_in = csr_wdata[6:0];
            default:      num_cols_in = num_cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= DEF_NUM_COLS;
         num_rows_ff <= DEF_NUM_ROWS;
      end else begin
         num_cols_ff <= num_cols_in;
         num_rows_ff <= num_rows_in;
      end
   end

   always_comb begin
      if (num_cols_ff == '0) begin
         cols = CW'(1);
      end else if (32'(num_cols_ff) > MAX_COLS) begin
         cols = CW'(MAX_COLS);
      end else begin
         cols = CW'(num_cols_ff);
      end
      if (num_rows_ff == '0) begin
         rows = RCW'(1);
      end else if (32'(num_rows_ff) > MAX_ROWS) begin
         rows = RCW'(MAX_ROWS);
      end else begin
         rows = RCW'(num_rows_ff);
      end
   end

   tcg_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (grid_wr_data),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   tcg_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_save_ram (
      .clock   (clock),
      .wr_en   (sv_wr_en),
      .wr_addr (sv_wr_addr),
      .wr_data (sv_wr_data),
      .rd_addr (sv_rd_addr),
      .rd_data (sv_rd_data)
   );

   tcg_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .char_code      (req_char_code),
      .cell_col       (req_cell_col),
      .cell_row       (req_cell_row),
      .cols           (cols),
      .rows           (rows),
      .rsp_valid      (rsp_valid),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_status     (rsp_status),
      .grid_wr_en     (grid_wr_en),
      .grid_wr_addr   (grid_wr_addr),
      .grid_wr_data   (grid_wr_data),
      .grid_rd_addr   (grid_rd_addr),
      .grid_rd_data   (grid_rd_data),
      .sv_wr_en       (sv_wr_en),
      .sv_wr_addr     (sv_wr_addr),
      .sv_wr_data     (sv_wr_data),
      .sv_rd_addr     (sv_rd_addr),
      .sv_rd_data     (sv_rd_data)
   );

endmodule

[src/tcg_ram.sv]
// Generic single write port, single read port RAM with registered read.
module tcg_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 8192,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tcg_addr.sv]
// Row and column to cell address mapping through the circular row base.
module tcg_addr
   import tcg_pkg::*;
#(
   parameter  int MAX_COLS = DEF_MAX_COLS,
   parameter  int MAX_ROWS = DEF_MAX_ROWS,
   localparam int RW       = $clog2(MAX_ROWS),
   localparam int RW1      = RW + 1,
   localparam int CAW      = $clog2(MAX_COLS),
   localparam int AW       = $clog2(MAX_COLS * MAX_ROWS)
) (
   input  logic [RW-1:0]  base,
   input  logic [RW-1:0]  row,
   input  logic [CAW-1:0] col,
   output logic [AW-1:0]  addr
);

   logic [RW1-1:0] sum;
   logic [RW-1:0]  phys;

   always_comb begin
      sum = RW1'(base) + RW1'(row);
      if (sum >= RW1'(MAX_ROWS)) begin
         phys = RW'(sum - RW1'(MAX_ROWS));
      end else begin
         phys = RW'(sum);
      end
      addr = AW'(phys) * AW'(MAX_COLS) + AW'(col);
   end

endmodule

[src/tcg_seq.sv]
// Sequencer: cursor state, save store bookkeeping and cell sweeps.
module tcg_seq
   import tcg_pkg::*;
#(
   parameter  int MAX_COLS = DEF_MAX_COLS,
   parameter  int MAX_ROWS = DEF_MAX_ROWS,
   parameter  int TAB_STOP = DEF_TAB_STOP,
   localparam int CW       = $clog2(MAX_COLS + 1),
   localparam int RCW      = $clog2(MAX_ROWS + 1),
   localparam int RW       = $clog2(MAX_ROWS),
   localparam int CAW      = $clog2(MAX_COLS),
   localparam int CELLS    = MAX_COLS * MAX_ROWS,
   localparam int AW       = $clog2(CELLS)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  logic [2:0]     req_type,
   input  logic [7:0]     char_code,
   input  logic [6:0]     cell_col,
   input  logic [5:0]     cell_row,
   input  logic [CW-1:0]  cols,
   input  logic [RCW-1:0] rows,
   output logic           rsp_valid,
   output logic [7:0]     rsp_cell_char,
   output logic [7:0]     rsp_cursor_col,
   output logic [5:0]     rsp_cursor_row,
   output logic           rsp_status,
   output logic           grid_wr_en,
   output logic [AW-1:0]  grid_wr_addr,
   output logic [7:0]     grid_wr_data,
   output logic [AW-1:0]  grid_rd_addr,
   input  logic [7:0]     grid_rd_data,
   output logic           sv_wr_en,
   output logic [AW-1:0]  sv_wr_addr,
   output logic [7:0]     sv_wr_data,
   output logic [AW-1:0]  sv_rd_addr,
   input  logic [7:0]     sv_rd_data
);

   localparam int TK    = 16;
   localparam int TAB_M = (2 ** TK + TAB_STOP - 1) / TAB_STOP;
   localparam int PW    = CW + TK;

   tcg_state_type  state_ff, state_in;
   logic [CW-1:0]  col_ff, col_in, sv_col_ff, sv_col_in;
   logic [RW-1:0]  row_ff, row_in, sv_row_ff, sv_row_in;
   logic [RW-1:0]  base_ff, base_in, sv_base_ff, sv_base_in;
   logic           sv_valid_ff, sv_valid_in;
   logic [2:0]     op_ff, op_in;
   logic [7:0]     chr_ff, chr_in;
   logic           tab_ff, tab_in;
   logic [6:0]     ccol_ff, ccol_in;
   logic [5:0]     crow_ff, crow_in;
   logic           ret_plain_ff, ret_plain_in;
   logic [AW-1:0]  swp_ff, swp_in, swp_end_ff, swp_end_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_addr_ff, pend_addr_in;
   logic [7:0]     cell_ff, cell_in;
   logic           status_ff, status_in;

   logic [RW-1:0]  row_op;
   logic [CAW-1:0] col_op;
   logic [AW-1:0]  cell_addr;
   logic [RCW-1:0] row_inc;
   logic [CW-1:0]  col_inc;
   logic [RW-1:0]  base_inc;
   logic [RW-1:0]  last_row;
   logic           wrap, scroll, in_range, tab_stop;
   logic [PW-1:0]  tab_prod;
   logic           sweep_end;

   tcg_addr #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_addr (
      .base (base_ff),
      .row  (row_op),
      .col  (col_op),
      .addr (cell_addr)
   );

   always_comb begin
      row_inc   = RCW'(row_ff) + RCW'(1);
      col_inc   = col_ff + CW'(1);
      base_inc  = (base_ff == RW'(MAX_ROWS - 1)) ? '0 : base_ff + RW'(1);
      last_row  = RW'(rows - RCW'(1));
      wrap      = (col_ff >= cols);
      scroll    = (row_inc >= rows);
      in_range  = (32'(crow_ff) < 32'(rows)) && (32'(ccol_ff) < 32'(cols));
      tab_prod  = PW'(col_inc) * PW'(TAB_M);
      tab_stop  = ((32'(cols) < TAB_STOP) && (col_inc >= cols)) ||
                  (tab_prod[TK-1:0] < TK'(TAB_M));
      sweep_end = (swp_ff == AW'(CELLS - 1));
   end

   always_comb begin
      row_op = row_ff;
      col_op = CAW'(col_ff);
      case (state_ff)
         ST_DISPATCH: begin
            if (op_ff == REQ_READ) begin
               row_op = RW'(crow_ff);
               col_op = CAW'(ccol_ff);
            end else begin
               col_op = CAW'(col_ff - CW'(1));
            end
         end
         ST_ROWSET: begin
            row_op = last_row;
            col_op = '0;
         end
         default: begin
            row_op = row_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (op_ff)
               REQ_PUT: begin
                  if (chr_ff == CH_NL) begin
                     state_in = scroll ? ST_ROWSET : ST_RESP;
                  end else if (chr_ff == CH_CR || chr_ff == CH_BS) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_PLAIN;
                  end
               end
               REQ_CLEAR:   state_in = ST_CLEAR;
               REQ_SAVE:    state_in = ST_COPY;
               REQ_RESTORE: state_in = sv_valid_ff ? ST_COPY : ST_RESP;
               REQ_READ:    state_in = in_range ? ST_RDCAP : ST_RESP;
               default:     state_in = ST_RESP;
            endcase
         end
         ST_PLAIN: begin
            if (wrap) begin
               state_in = scroll ? ST_ROWSET : ST_PLAIN;
            end else if (tab_ff && !tab_stop) begin
               state_in = ST_PLAIN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_ROWSET: state_in = ST_ROWCLR;
         ST_ROWCLR: begin
            if (swp_ff == swp_end_ff) state_in = ret_plain_ff ? ST_PLAIN : ST_RESP;
         end
         ST_CLEAR: begin
            if (sweep_end) state_in = ST_RESP;
         end
         ST_COPY: begin
            if (sweep_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RDCAP: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      sv_col_in    = sv_col_ff;
      sv_row_in    = sv_row_ff;
      sv_base_in   = sv_base_ff;
      sv_valid_in  = sv_valid_ff;
      op_in        = op_ff;
      chr_in       = chr_ff;
      tab_in       = tab_ff;
      ccol_in      = ccol_ff;
      crow_in      = crow_ff;
      ret_plain_in = ret_plain_ff;
      swp_in       = swp_ff;
      swp_end_in   = swp_end_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cell_in      = cell_ff;
      status_in    = status_ff;
      grid_wr_en   = 1'b0;
      grid_wr_addr = cell_addr;
      grid_wr_data = CH_BLANK;
      grid_rd_addr = cell_addr;
      sv_wr_en     = 1'b0;
      sv_wr_addr   = pend_addr_ff;
      sv_wr_data   = grid_rd_data;
      sv_rd_addr   = swp_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR, ST_ROWCLR: begin
            grid_wr_en   = 1'b1;
            grid_wr_addr = swp_ff;
            swp_in       = swp_ff + AW'(1);
         end
         ST_IDLE: begin
            if (RCW'(row_ff) >= rows) row_in = last_row;
            if (col_ff > cols) col_in = cols;
            if (start) begin
               op_in     = req_type;
               chr_in    = char_code;
               ccol_in   = cell_col;
               crow_in   = cell_row;
               cell_in   = CH_BLANK;
               status_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            case (op_ff)
               REQ_PUT: begin
                  tab_in = 1'b0;
                  if (chr_ff == CH_NL) begin
                     col_in       = '0;
                     ret_plain_in = 1'b0;
                     if (scroll) begin
                        base_in = base_inc;
                        row_in  = last_row;
                     end else begin
                        row_in  = RW'(row_inc);
                     end
                  end else if (chr_ff == CH_CR) begin
                     col_in = '0;
                  end else if (chr_ff == CH_BS) begin
                     if (col_ff != '0) begin
                        col_in     = col_ff - CW'(1);
                        grid_wr_en = 1'b1;
                     end
                  end else if (chr_ff == CH_TAB) begin
                     chr_in = CH_SPACE;
                     tab_in = 1'b1;
                  end
               end
               REQ_CLEAR: begin
                  base_in = '0;
                  col_in  = '0;
                  row_in  = '0;
                  swp_in  = '0;
               end
               REQ_SAVE: begin
                  sv_col_in   = col_ff;
                  sv_row_in   = row_ff;
                  sv_base_in  = base_ff;
                  sv_valid_in = 1'b1;
                  base_in     = '0;
                  col_in      = '0;
                  row_in      = '0;
                  swp_in      = '0;
                  pend_in     = 1'b0;
               end
               REQ_RESTORE: begin
                  if (sv_valid_ff) begin
                     base_in     = sv_base_ff;
                     col_in      = (sv_col_ff > cols) ? cols : sv_col_ff;
                     row_in      = (RCW'(sv_row_ff) >= rows) ? last_row : sv_row_ff;
                     sv_valid_in = 1'b0;
                     swp_in      = '0;
                     pend_in     = 1'b0;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               default: begin
                  status_in = 1'b0;
               end
            endcase
         end
         ST_PLAIN: begin
            if (wrap) begin
               col_in       = '0;
               ret_plain_in = 1'b1;
               if (scroll) begin
                  base_in = base_inc;
                  row_in  = last_row;
               end else begin
                  row_in  = RW'(row_inc);
               end
            end else begin
               grid_wr_en   = 1'b1;
               grid_wr_data = chr_ff;
               col_in       = col_inc;
            end
         end
         ST_ROWSET: begin
            swp_in     = cell_addr;
            swp_end_in = cell_addr + AW'(MAX_COLS - 1);
         end
         ST_COPY, ST_DRAIN: begin
            if (state_ff == ST_COPY) begin
               grid_rd_addr = swp_ff;
               pend_in      = 1'b1;
               pend_addr_in = swp_ff;
               swp_in       = swp_ff + AW'(1);
            end else begin
               pend_in      = 1'b0;
            end
            if (pend_ff) begin
               grid_wr_en   = 1'b1;
               grid_wr_addr = pend_addr_ff;
               if (op_ff == REQ_SAVE) begin
                  sv_wr_en     = 1'b1;
                  grid_wr_data = CH_BLANK;
               end else begin
                  grid_wr_data = sv_rd_data;
               end
            end
         end
         ST_RDCAP: begin
            cell_in = grid_rd_data;
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_comb begin
      busy           = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_RESP);
      rsp_cell_char  = cell_ff;
      rsp_cursor_col = 8'(col_ff);
      rsp_cursor_row = 6'(row_ff);
      rsp_status     = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         sv_col_ff    <= '0;
         sv_row_ff    <= '0;
         sv_base_ff   <= '0;
         sv_valid_ff  <= 1'b0;
         swp_ff       <= '0;
         pend_ff      <= 1'b0;
         tab_ff       <= 1'b0;
         ret_plain_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         sv_col_ff    <= sv_col_in;
         sv_row_ff    <= sv_row_in;
         sv_base_ff   <= sv_base_in;
         sv_valid_ff  <= sv_valid_in;
         swp_ff       <= swp_in;
         pend_ff      <= pend_in;
         tab_ff       <= tab_in;
         ret_plain_ff <= ret_plain_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      chr_ff       <= chr_in;
      ccol_ff      <= ccol_in;
      crow_ff      <= crow_in;
      swp_end_ff   <= swp_end_in;
      pend_addr_ff <= pend_addr_in;
      cell_ff      <= cell_in;
      status_ff    <= status_in;
   end

endmodule

[test/text_console_grid_engine_tb.sv]
// Self-checking testbench for the text console grid engine: directed and random console requests.
`timescale 1ns / 100ps

module text_console_grid_engine_tb
   import tcg_pkg::*;
();

   localparam int GRID_COLS  = DEF_MAX_COLS;
   localparam int GRID_ROWS  = DEF_MAX_ROWS;
   localparam int TAB_WIDTH  = DEF_TAB_STOP;
   localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
   localparam int MAX_GAP    = 18;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] code;
      logic [6:0] col;
      logic [5:0] row;
      logic       drain;
   } console_item_type;

   typedef struct packed {
      logic [7:0] glyph;
      logic [7:0] ccol;
      logic [5:0] crow;
      logic       status;
   } console_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [2:0]           req_type = REQ_PUT;
   logic [7:0]           req_char_code = 8'd0;
   logic [6:0]           req_cell_col = 7'd0;
   logic [5:0]           req_cell_row = 6'd0;
   logic                 rsp_valid;
   logic [7:0]           rsp_cell_char;
   logic [7:0]           rsp_cursor_col;
   logic [5:0]           rsp_cursor_row;
   logic                 rsp_status;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NUM_COLS;
   logic [7:0]           csr_wdata = 8'd0;

   console_item_type pending_req_q[$];
   console_rsp_type  awaited_rsp_q[$];
   console_item_type cur_item;
   int            idle_gap = 0;
   bit            idle_on = 1'b1;
   int            mismatch_count = 0;
   longint        cycle_count = 0;
   longint        watch_limit = 4 * GRID_CELLS + 20000;

   logic [7:0]  grid_mem  [0:GRID_CELLS-1];
   logic [7:0]  saved_mem [0:GRID_CELLS-1];
   int unsigned base_row, cur_col, cur_row;
   int unsigned sv_base, sv_col, sv_row;
   bit          sv_valid;
   logic [7:0]  cfg_cols = DEF_NUM_COLS;
   logic [6:0]  cfg_rows = DEF_NUM_ROWS;

   text_console_grid_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .rsp_valid      (rsp_valid),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned cols_in_use();
      if (cfg_cols == 8'd0) return 1;
      if (cfg_cols > GRID_COLS) return GRID_COLS;
      return cfg_cols;
   endfunction

   function automatic int unsigned rows_in_use();
      if (cfg_rows == 7'd0) return 1;
      if (cfg_rows > GRID_ROWS) return GRID_ROWS;
      return cfg_rows;
   endfunction

   function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
      return ((base_row + r) % GRID_ROWS) * GRID_COLS + (c % GRID_COLS);
   endfunction

   function automatic void clamp_cursor();
      if (cur_row >= rows_in_use()) cur_row = rows_in_use() - 1;
      if (cur_col > cols_in_use()) cur_col = cols_in_use();
   endfunction

   function automatic void blank_screen();
      int i;
      for (i = 0; i < GRID_CELLS; i++) grid_mem[i] = CH_BLANK;
      base_row = 0;
      cur_col = 0;
      cur_row = 0;
   endfunction

   function automatic void line_feed();
      int unsigned rows;
      int          c;
      rows = rows_in_use();
      cur_col = 0;
      cur_row++;
      if (cur_row >= rows) begin
         base_row = (base_row + 1) % GRID_ROWS;
         for (c = 0; c < GRID_COLS; c++) grid_mem[cell_addr(rows - 1, c)] = CH_BLANK;
         cur_row = rows - 1;
      end
   endfunction

   function automatic void store_glyph(logic [7:0] ch);
      if (cur_col >= cols_in_use()) line_feed();
      grid_mem[cell_addr(cur_row, cur_col)] = ch;
      cur_col++;
   endfunction

   function automatic console_rsp_type console_step(console_item_type it);
      console_rsp_type rsp;
      int unsigned  cols;
      bit           tab_done;
      int           i;
      cols = cols_in_use();
      rsp = '0;
      case (it.kind)
         REQ_PUT: begin
            if (it.code == CH_NL) begin
               line_feed();
            end else if (it.code == CH_CR) begin
               cur_col = 0;
            end else if (it.code == CH_BS) begin
               if (cur_col > 0) begin
                  cur_col--;
                  grid_mem[cell_addr(cur_row, cur_col)] = CH_BLANK;
               end
            end else if (it.code == CH_TAB) begin
               tab_done = 1'b0;
               do begin
                  store_glyph(CH_SPACE);
                  if ((cols < TAB_WIDTH && cur_col >= cols) || (cur_col % TAB_WIDTH) == 0)
                     tab_done = 1'b1;
               end while (!tab_done);
            end else begin
               store_glyph(it.code);
            end
         end
         REQ_CLEAR: begin
            blank_screen();
         end
         REQ_SAVE: begin
            for (i = 0; i < GRID_CELLS; i++) saved_mem[i] = grid_mem[i];
            sv_base = base_row;
            sv_col = cur_col;
            sv_row = cur_row;
            sv_valid = 1'b1;
            blank_screen();
         end
         REQ_RESTORE: begin
            if (!sv_valid) begin
               rsp.status = 1'b1;
            end else begin
               for (i = 0; i < GRID_CELLS; i++) grid_mem[i] = saved_mem[i];
               base_row = sv_base;
               cur_col = sv_col;
               cur_row = sv_row;
               sv_valid = 1'b0;
               clamp_cursor();
            end
         end
         REQ_READ: begin
            if (it.col < cols && it.row < rows_in_use())
               rsp.glyph = grid_mem[cell_addr(it.row, it.col)];
         end
         default: begin
         end
      endcase
      rsp.ccol = cur_col[7:0];
      rsp.crow = cur_row[5:0];
      return rsp;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_req(logic [2:0] kind, logic [7:0] code, logic [6:0] col,
                           logic [5:0] row, logic drain);
      console_item_type it;
      it.kind = kind;
      it.code = code;
      it.col = col;
      it.row = row;
      it.drain = drain;
      pending_req_q.push_back(it);
      if (kind == REQ_CLEAR || kind == REQ_SAVE || kind == REQ_RESTORE)
         watch_limit += 4 * (GRID_CELLS + 40 + MAX_GAP);
      else
         watch_limit += 4 * (1200 + MAX_GAP);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [7:0] data);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_NUM_COLS) cfg_cols = data;
      else if (idx == CSR_NUM_ROWS) cfg_rows = data[6:0];
      clamp_cursor();
      csr_valid <= 1'b0;
      watch_limit += 1000;
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || start || awaited_rsp_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic fill_phase(int count);
      int          n, pick, sel;
      logic [7:0]  code;
      logic [6:0]  col;
      logic [5:0]  row;
      logic [2:0]  kind;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 199);
         code = 8'($urandom_range(0, 255));
         col = 7'($urandom_range(0, 127));
         row = 6'($urandom_range(0, 63));
         if (pick < 3) begin
            kind = REQ_CLEAR;
         end else if (pick < 6) begin
            kind = REQ_SAVE;
         end else if (pick < 9) begin
            kind = REQ_RESTORE;
         end else if (pick < 15) begin
            kind = REQ_READ + 3'($urandom_range(1, 3));
         end else if (pick < 65) begin
            kind = REQ_READ;
            if ($urandom_range(0, 9) < 7) begin
               col = 7'($urandom_range(0, cols_in_use() - 1));
               row = 6'($urandom_range(0, rows_in_use() - 1));
            end
         end else begin
            kind = REQ_PUT;
            sel = $urandom_range(0, 99);
            if (sel < 55) code = 8'($urandom_range(32, 126));
            else if (sel < 67) code = CH_NL;
            else if (sel < 72) code = CH_CR;
            else if (sel < 79) code = CH_BS;
            else if (sel < 85) code = CH_TAB;
         end
         push_req(kind, code, col, row, $urandom_range(0, 99) == 0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            awaited_rsp_q.push_back(console_step(cur_item));
            if (idle_on && $urandom_range(0, 3) == 0) idle_gap = $urandom_range(1, MAX_GAP);
         end
         if (!start || !busy) begin
            if (idle_gap > 0) begin
               idle_gap--;
               start <= 1'b0;
            end else if (pending_req_q.size() > 0 && (!pending_req_q[0].drain ||
                         (awaited_rsp_q.size() == 0 && !rsp_valid))) begin
               cur_item = pending_req_q.pop_front();
               req_type <= cur_item.kind;
               req_char_code <= cur_item.code;
               req_cell_col <= cur_item.col;
               req_cell_row <= cur_item.row;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp_q.size() == 0) begin
            report_mismatch("result with nothing pending, cursor_col", rsp_cursor_col, 0);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_cell_char !== want.glyph)
               report_mismatch("cell_char", rsp_cell_char, want.glyph);
            if (rsp_cursor_col !== want.ccol)
               report_mismatch("cursor_col", rsp_cursor_col, want.ccol);
            if (rsp_cursor_row !== want.crow)
               report_mismatch("cursor_row", rsp_cursor_row, want.crow);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > watch_limit) begin
         $display("text_console_grid_engine: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0] phase_cols [0:9];
      logic [7:0] phase_rows [0:9];
      int         p;
      phase_cols = '{8'd80, 8'd128, 8'd255, 8'd0, 8'd1, 8'd7, 8'd8, 8'd16, 8'd0, 8'd40};
      phase_rows = '{8'd25, 8'd64, 8'd255, 8'd0, 8'd1, 8'd3, 8'd2, 8'd5, 8'd0, 8'd12};
      phase_cols[8] = 8'($urandom_range(0, 255));
      phase_rows[8] = 8'($urandom_range(0, 255));
      blank_screen();
      sv_base = 0;
      sv_col = 0;
      sv_row = 0;
      sv_valid = 1'b0;
      for (p = 0; p < GRID_CELLS; p++) saved_mem[p] = CH_BLANK;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_NUM_COLS, 8'd4);
      write_csr(CSR_NUM_ROWS, 8'd2);
      push_req(REQ_RESTORE, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd127, 6'd63, 1'b0);
      push_req(REQ_PUT, 8'd65, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, 8'd255, 7'd127, 6'd63, 1'b0);
      push_req(REQ_PUT, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, 8'd66, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, CH_BS, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, 8'd67, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, 8'd68, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, CH_TAB, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, CH_NL, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, CH_BS, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, 8'd69, 7'd0, 6'd0, 1'b0);
      push_req(REQ_PUT, CH_CR, 7'd0, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd3, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd0, 6'd1, 1'b0);
      push_req(REQ_SAVE, 8'd0, 7'd0, 6'd0, 1'b1);
      push_req(REQ_PUT, 8'd120, 7'd0, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_RESTORE, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_READ, 8'd0, 7'd0, 6'd0, 1'b0);
      push_req(REQ_CLEAR, 8'd255, 7'd127, 6'd63, 1'b0);
      push_req(REQ_READ + 3'd1, 8'd170, 7'd85, 6'd42, 1'b0);
      push_req(REQ_READ + 3'd2, 8'd85, 7'd42, 6'd21, 1'b0);
      push_req(REQ_READ + 3'd3, 8'd0, 7'd0, 6'd0, 1'b0);
      wait_quiet();

      for (p = 0; p < 10; p++) begin
         write_csr(CSR_NUM_COLS, phase_cols[p]);
         write_csr(CSR_NUM_ROWS, phase_rows[p]);
         idle_on = (p != 9) && ($urandom_range(0, 3) != 0);
         fill_phase(105);
         wait_quiet();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("text_console_grid_engine: match");
      end else begin
         $display("text_console_grid_engine: mismatch");
      end
      $finish;
   end

endmodule

[text_console_grid_engine.f]
src/tcg_pkg.sv
src/tcg_ram.sv
src/tcg_addr.sv
src/tcg_seq.sv
src/text_console_grid_engine.sv
test/text_console_grid_engine_tb.sv
